/* rtl/dtmf_tone_generator_top_assert.svh */
// assertion macros for the dtmf tone generator checks
`ifndef DTMF_TONE_GENERATOR_TOP_ASSERT_SVH
`define DTMF_TONE_GENERATOR_TOP_ASSERT_SVH

// property held outside reset
`define DTMF_ASSERT_RUN(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dtmf check failed");

// property held at every edge, reset included
`define DTMF_ASSERT_ALL(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dtmf check failed");

`endif

/* rtl/dtmf_pkg.sv */
// types, constants and table builder shared by the dtmf tone generator
`default_nettype none
package dtmf_pkg;

  localparam int INDEX_W = 24;
  localparam int SYMBOL_W = 8;
  localparam int SAMPLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int PHASE_W = 13;
  localparam int ROM_AW = 11;
  localparam int COS_DEPTH = 2001;
  localparam int NUM_TONES = 8;
  localparam int NUM_TERMS = 12;

  // quarter wave in phase units; one table step per phase unit
  localparam logic [PHASE_W-1:0] QUARTER = 13'd2000;
  localparam logic [PHASE_W-1:0] HALF = 13'd4000;
  localparam logic [PHASE_W-1:0] THREE_Q = 13'd6000;
  localparam logic [PHASE_W-1:0] FULL_TURN = 13'd8000;

  localparam logic [INDEX_W-1:0] TOTAL_RESET = 24'd8000;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_KEY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic REG_TOTAL_SAMPLES = 1'b0;

  // rows first, then columns
  localparam logic [PHASE_W-1:0] TONE_STEP [NUM_TONES] = '{
    13'd697, 13'd770, 13'd852, 13'd941, 13'd1209, 13'd1336, 13'd1477, 13'd1633
  };

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint AMPLITUDE = 64'sd32767;
  localparam longint QSTEPS = 64'sd2000;
  localparam longint ANGLE_DIV = 64'sd2 * QSTEPS;

  // (2n+1)(2n+2) for each series term
  localparam longint TERM_DIV [NUM_TERMS] = '{
    64'sd2, 64'sd12, 64'sd30, 64'sd56, 64'sd90, 64'sd132,
    64'sd182, 64'sd240, 64'sd306, 64'sd380, 64'sd462, 64'sd552
  };

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
    logic [1:0] col;
  } key_t;

  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
  } cos_val_t;

  typedef logic [14:0] cos_rom_t [COS_DEPTH];

  function automatic key_t decode_key(input logic [SYMBOL_W-1:0] s);
    key_t k;
    k = '{valid: 1'b1, row: 2'd0, col: 2'd0};
    case (s)
      "1": begin k.row = 2'd0; k.col = 2'd0; end
      "2": begin k.row = 2'd0; k.col = 2'd1; end
      "3": begin k.row = 2'd0; k.col = 2'd2; end
      "A": begin k.row = 2'd0; k.col = 2'd3; end
      "4": begin k.row = 2'd1; k.col = 2'd0; end
      "5": begin k.row = 2'd1; k.col = 2'd1; end
      "6": begin k.row = 2'd1; k.col = 2'd2; end
      "B": begin k.row = 2'd1; k.col = 2'd3; end
      "7": begin k.row = 2'd2; k.col = 2'd0; end
      "8": begin k.row = 2'd2; k.col = 2'd1; end
      "9": begin k.row = 2'd2; k.col = 2'd2; end
      "C": begin k.row = 2'd2; k.col = 2'd3; end
      "*": begin k.row = 2'd3; k.col = 2'd0; end
      "0": begin k.row = 2'd3; k.col = 2'd1; end
      "#": begin k.row = 2'd3; k.col = 2'd2; end
      "D": begin k.row = 2'd3; k.col = 2'd3; end
      default: k.valid = 1'b0;
    endcase
    return k;
  endfunction

  // q30 taylor series of the cosine, scaled and rounded half away from zero
  function automatic logic [14:0] cos_entry(input int k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    x = (PI_Q30 * longint'(k)) / ANGLE_DIV;
    x2 = (x * x) / ONE_Q30;
    term = ONE_Q30;
    sum = ONE_Q30;
    for (int n = 0; n < NUM_TERMS; n++) begin
      term = -((term * x2) / ONE_Q30) / TERM_DIV[n];
      sum = sum + term;
    end
    if (sum >= 0) begin
      v = (sum * AMPLITUDE + ONE_Q30 / 2) / ONE_Q30;
    end else begin
      v = -((-sum * AMPLITUDE + ONE_Q30 / 2) / ONE_Q30);
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > AMPLITUDE) begin
      v = AMPLITUDE;
    end
    return v[14:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int k = 0; k < COS_DEPTH; k++) begin
      rom[k] = cos_entry(k);
    end
    return rom;
  endfunction

endpackage
`default_nettype wire

/* rtl/dtmf_cos_rom.sv */
// quarter-wave cosine table with two registered read ports and phase folding
`default_nettype none
module dtmf_cos_rom (
  input  wire                                 clk,
  input  wire                                 en,
  input  wire  [dtmf_pkg::PHASE_W-1:0]        phase_a,
  input  wire  [dtmf_pkg::PHASE_W-1:0]        phase_b,
  output dtmf_pkg::cos_val_t                  val_a,
  output dtmf_pkg::cos_val_t                  val_b
);
  import dtmf_pkg::*;

  localparam cos_rom_t ROM = build_cos_rom();

  logic [ROM_AW-1:0] idx_a;
  logic [ROM_AW-1:0] idx_b;
  logic              neg_a;
  logic              neg_b;

  function automatic logic [ROM_AW:0] fold(input logic [PHASE_W-1:0] p);
    logic [PHASE_W-1:0] i;
    logic               n;
    if (p <= QUARTER) begin
      i = p;
      n = 1'b0;
    end else if (p <= HALF) begin
      i = HALF - p;
      n = 1'b1;
    end else if (p <= THREE_Q) begin
      i = p - HALF;
      n = 1'b1;
    end else begin
      i = FULL_TURN - p;
      n = 1'b0;
    end
    return {n, i[ROM_AW-1:0]};
  endfunction

  assign {neg_a, idx_a} = fold(phase_a);
  assign {neg_b, idx_b} = fold(phase_b);

  always_ff @(posedge clk) begin
    if (en) begin
      val_a.neg <= neg_a;
      val_a.mag <= ROM[idx_a];
      val_b.neg <= neg_b;
      val_b.mag <= ROM[idx_b];
    end
  end

endmodule
`default_nettype wire

/* rtl/dtmf_tone_generator_top.sv */
// dtmf tone generator: event store, phase bank, table read and output register
// a word taken passes the table read stage, then the output register, before rsp_valid
// throughput: one word per cycle unless a low rsp_ready holds the output; the table read and
// the output register form two stages, so a new word is taken while a result waits
// reset: synchronous; clears the sample index, phases and event, total_samples to 8000
`default_nettype none
module dtmf_tone_generator_top (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 req_valid,
  output logic                                req_ready,
  input  wire                                 op,
  input  wire  [dtmf_pkg::INDEX_W-1:0]        start_index,
  input  wire  [dtmf_pkg::INDEX_W-1:0]        end_index,
  input  wire  [dtmf_pkg::SYMBOL_W-1:0]       symbol,
  output logic                                rsp_valid,
  input  wire                                 rsp_ready,
  output logic signed [dtmf_pkg::SAMPLE_W-1:0] sample,
  output logic [dtmf_pkg::STATUS_W-1:0]       status,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [2:0]                          paddr,
  input  wire  [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import dtmf_pkg::*;

  logic [INDEX_W-1:0] total_samples;
  logic [INDEX_W-1:0] counter;
  logic [INDEX_W-1:0] ev_start;
  logic [INDEX_W-1:0] ev_end;
  logic [1:0]         ev_row;
  logic [1:0]         ev_col;
  logic               ev_loaded;
  logic [PHASE_W-1:0] phase [NUM_TONES];
  logic [PHASE_W-1:0] phase_next [NUM_TONES];
  logic [PHASE_W:0]   phase_sum [NUM_TONES];

  logic               accept;
  key_t               key;
  logic               load_ok;
  logic [STATUS_W-1:0] status_next;
  logic               active_next;
  logic               counter_wrap;

  logic               s1_valid;
  logic               s1_active;
  logic [STATUS_W-1:0] s1_status;
  logic               s1_move;
  cos_val_t           cos_row;
  cos_val_t           cos_col;

  logic signed [16:0] v_row;
  logic signed [16:0] v_col;
  logic signed [17:0] sum;
  logic signed [17:0] sum_adj;
  logic signed [SAMPLE_W-1:0] sample_next;

  // configuration port
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_TOTAL_SAMPLES) begin
      prdata = {8'd0, total_samples};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_samples <= TOTAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOTAL_SAMPLES) begin
      total_samples <= pwdata[INDEX_W-1:0];
    end
  end

  // request side
  assign s1_move = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_move;
  assign accept = req_valid && req_ready;

  assign key = decode_key(symbol);
  assign load_ok = key.valid && (end_index <= total_samples);
  assign counter_wrap = (counter == {INDEX_W{1'b1}});
  assign active_next = ev_loaded && (counter >= ev_start) && (counter < ev_end);

  always_comb begin
    status_next = STATUS_OK;
    if (op == OP_LOAD) begin
      if (!key.valid) begin
        status_next = STATUS_BAD_KEY;
      end else if (end_index > total_samples) begin
        status_next = STATUS_TOO_LONG;
      end
    end
  end

  // phase of every keypad tone tracks freq * index mod sample rate
  always_comb begin
    for (int t = 0; t < NUM_TONES; t++) begin
      phase_sum[t] = {1'b0, phase[t]} + {1'b0, TONE_STEP[t]};
      if (counter_wrap) begin
        phase_next[t] = '0;
      end else if (phase_sum[t] >= {1'b0, FULL_TURN}) begin
        phase_next[t] = phase_sum[t][PHASE_W-1:0] - FULL_TURN;
      end else begin
        phase_next[t] = phase_sum[t][PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      ev_loaded <= 1'b0;
      ev_start <= '0;
      ev_end <= '0;
      ev_row <= '0;
      ev_col <= '0;
      for (int t = 0; t < NUM_TONES; t++) begin
        phase[t] <= '0;
      end
    end else if (accept) begin
      if (op == OP_LOAD) begin
        if (load_ok) begin
          ev_loaded <= 1'b1;
          ev_start <= start_index;
          ev_end <= end_index;
          ev_row <= key.row;
          ev_col <= key.col;
        end
      end else begin
        counter <= counter + 1'b1;
        for (int t = 0; t < NUM_TONES; t++) begin
          phase[t] <= phase_next[t];
        end
      end
    end
  end

  // table read stage
  dtmf_cos_rom u_rom (
    .clk     (clk),
    .en      (accept),
    .phase_a (phase[{1'b0, ev_row}]),
    .phase_b (phase[{1'b1, ev_col}]),
    .val_a   (cos_row),
    .val_b   (cos_col)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_active <= (op == OP_TICK) && active_next;
      s1_status <= status_next;
    end
  end

  // sum of the two tones, halved toward zero; zero outside an active tick
  assign v_row = cos_row.neg ? -$signed({2'b00, cos_row.mag}) : $signed({2'b00, cos_row.mag});
  assign v_col = cos_col.neg ? -$signed({2'b00, cos_col.mag}) : $signed({2'b00, cos_col.mag});
  assign sum = {v_row[16], v_row} + {v_col[16], v_col};
  assign sum_adj = sum + $signed({17'd0, sum[17]});
  assign sample_next = s1_active ? sum_adj[16:1] : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      sample <= sample_next;
      status <= s1_status;
    end
  end

endmodule
`default_nettype wire

/* rtl/dtmf_checker.sv */
// port-level checks for the dtmf tone generator, bound to the top level
`default_nettype none
`include "dtmf_tone_generator_top_assert.svh"
module dtmf_checker (
  input wire                                  clk,
  input wire                                  rst,
  input wire                                  req_valid,
  input wire                                  req_ready,
  input wire                                  rsp_valid,
  input wire                                  rsp_ready,
  input wire signed [dtmf_pkg::SAMPLE_W-1:0]  sample,
  input wire [dtmf_pkg::STATUS_W-1:0]         status
);
  import dtmf_pkg::*;

  // a waiting word keeps its value
  `DTMF_ASSERT_RUN(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample) && $stable(status))
  // rejected loads carry a silent sample
  `DTMF_ASSERT_RUN(a_err_silent, clk, rst, rsp_valid && status != STATUS_OK |-> sample == 16'sd0)
  // the two halved tones never reach the negative limit
  `DTMF_ASSERT_RUN(a_sample_range, clk, rst, rsp_valid |-> sample != 16'sh8000)
  // reset empties the pipe and opens the request side
  `DTMF_ASSERT_ALL(a_reset_empty, clk, rst |=> !rsp_valid && req_ready)

endmodule

bind dtmf_tone_generator_top dtmf_checker u_dtmf_checker (.*);
`default_nettype wire
